FILE: rtl/core/sensor_average_to_segment_digits_core_assert.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef SENSOR_AVERAGE_TO_SEGMENT_DIGITS_CORE_ASSERT_SVH
`define SENSOR_AVERAGE_TO_SEGMENT_DIGITS_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SASD_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sasd: implication check failed");

// Next-cycle implication, held off during reset.
`define SASD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sasd: next-cycle check failed");

`endif

FILE: rtl/core/sasd_pkg.sv
`default_nettype none
package sasd_pkg;

  // Configuration register
  localparam int unsigned      SAMPLE_COUNT_W     = 13;
  localparam logic [12:0]      SAMPLE_COUNT_RESET = 13'd1000;
  localparam int unsigned      CFG_ADDR_W         = 3;
  localparam logic [0:0]       CFG_IDX_SAMPLE_COUNT = 1'b0;

  // Fixed-point constants, Q16 unless noted
  localparam int unsigned      QUOT_W   = 18;
  localparam logic [17:0]      V_SCALE  = 18'd216269;
  localparam logic [17:0]      C_OFFSET = 18'd26214;
  localparam logic [22:0]      C_GAIN   = 23'd3360821;
  localparam logic [23:0]      F_GAIN   = 24'd6049477;
  localparam logic [22:0]      F_OFFSET = 23'd4516943;
  localparam int unsigned      GAIN_W   = 25;
  localparam int unsigned      PROD_W   = 44;
  localparam logic signed [PROD_W-1:0] F_OFFSET_Q32 =
    signed'(PROD_W'({F_OFFSET, 16'h0000}));
  localparam int unsigned      READ_LSB = 32;
  localparam int unsigned      READ_W   = 8;

  // Segment patterns
  localparam logic [7:0] SEG_C = 8'h39;
  localparam logic [7:0] SEG_F = 8'h71;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_GAIN,
    BK_CONVERT,
    BK_SPLIT,
    BK_EMIT
  } back_state_t;

  // Digit position within one reading
  typedef enum logic [1:0] {
    POS_HUND,
    POS_TENS,
    POS_ONES,
    POS_UNIT
  } digit_pos_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sasd_front.sv
`default_nettype none
module sasd_front #(
  parameter int unsigned ADC_BITS    = 12,
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned IN_DATA_W   = 16,
  parameter int unsigned SUM_W       = 24,
  parameter int unsigned CNT_W       = 13,
  parameter int unsigned JOB_W       = 38
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [sasd_pkg::SAMPLE_COUNT_W-1:0]  sample_count,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [IN_DATA_W-1:0]                 in_tdata,
  input  wire logic                                 in_tuser,
  input  wire sasd_pkg::queue_status_t              q_status,
  output logic                                      q_push,
  output logic [JOB_W-1:0]                          q_job
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0] win_len;
  logic [31:0]      count_ext;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] taken_inc;
  logic             accept;
  logic             closing;

  // Clamp the window length into 1..MAX_SAMPLES
  assign count_ext = 32'(sample_count);
  always_comb begin
    if (count_ext == 32'd0) begin
      win_len = CNT_W'(1);
    end else if (count_ext > 32'(MAX_SAMPLES)) begin
      win_len = CNT_W'(MAX_SAMPLES);
    end else begin
      win_len = CNT_W'(sample_count);
    end
  end

  // Accumulate and detect the window-closing item
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign sum_add   = sum_r + SUM_W'(in_tdata[ADC_BITS-1:0]);
  assign taken_inc = taken_r + CNT_W'(1);
  assign closing   = taken_inc >= win_len;

  always_comb begin
    sum_nxt   = sum_r;
    taken_nxt = taken_r;
    if (accept) begin
      if (closing) begin
        sum_nxt   = '0;
        taken_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        taken_nxt = taken_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      taken_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
    end
  end

  // Hand the finished window to the back end
  assign q_push = accept && closing;
  assign q_job  = {sum_add, taken_inc, in_tuser};

endmodule
`default_nettype wire

FILE: rtl/core/sasd_queue.sv
`default_nettype none
module sasd_queue #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire logic [WIDTH-1:0]         push_data,
  input  wire logic                     pop,
  output logic [WIDTH-1:0]              pop_data,
  output sasd_pkg::queue_status_t       status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sasd_back.sv
`default_nettype none
module sasd_back #(
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned SUM_W    = 24,
  parameter int unsigned CNT_W    = 13,
  parameter int unsigned JOB_W    = 38
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sasd_pkg::queue_status_t  q_status,
  input  wire logic [JOB_W-1:0]         q_job,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [7:0]                    out_tdata,
  output logic                          out_tlast
);

  localparam int unsigned QW      = sasd_pkg::QUOT_W;
  localparam int unsigned PW      = sasd_pkg::PROD_W;
  localparam int unsigned SCALE_W = SUM_W + QW;
  localparam int unsigned DEN_W   = CNT_W + ADC_BITS;
  localparam int unsigned DSH_W   = DEN_W + QW - 1;
  localparam int unsigned WORK_W  = (SCALE_W > DSH_W) ? SCALE_W : DSH_W;
  localparam int unsigned STEP_W  = $clog2(QW);
  localparam logic [15:0] DIV10_MUL   = 16'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  sasd_pkg::back_state_t state_r, state_nxt;

  logic                  out_load;
  logic [SUM_W-1:0]      job_sum;
  logic [CNT_W-1:0]      job_cnt;
  logic [SCALE_W-1:0]    scaled;
  logic [DEN_W-1:0]      divisor;
  logic                  fahr_r;
  logic [WORK_W-1:0]     rem_r;
  logic [WORK_W-1:0]     den_r;
  logic [QW-1:0]         quot_r;
  logic [STEP_W-1:0]     step_r;
  logic                  rem_ge;
  logic [QW:0]           quot_ext;
  logic signed [QW:0]    mul_a;
  logic signed [sasd_pkg::GAIN_W-1:0] mul_b;
  logic signed [PW-1:0]  prod_c;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  p_c;
  logic [7:0]            reading_r;
  logic [3:0]            hund_c;
  logic [7:0]            rem100_c;
  logic [15:0]           tens_prod;
  logic [3:0]            tens_c;
  logic [7:0]            ones_c;
  logic [3:0]            hund_r;
  logic [3:0]            tens_r;
  logic [3:0]            ones_r;
  sasd_pkg::digit_pos_t  pos_r;
  sasd_pkg::digit_pos_t  pos_start;
  logic [7:0]            seg_c;
  logic                  out_tvalid_r;
  logic [7:0]            out_tdata_r;
  logic                  out_tlast_r;

  // Unpack the queued window: sum, sample count, unit flag
  assign job_sum = q_job[JOB_W-1 -: SUM_W];
  assign job_cnt = q_job[CNT_W:1];
  assign scaled  = SCALE_W'(job_sum) * SCALE_W'(sasd_pkg::V_SCALE);
  assign divisor = (DEN_W'(job_cnt) << ADC_BITS) - DEN_W'(job_cnt);

  assign out_load = !out_tvalid_r || out_tready;

  // Sequence one reading at a time
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      sasd_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          state_nxt = sasd_pkg::BK_DIVIDE;
        end
      end
      sasd_pkg::BK_DIVIDE: begin
        if (step_r == STEP_W'(QW - 1)) begin
          state_nxt = sasd_pkg::BK_GAIN;
        end
      end
      sasd_pkg::BK_GAIN:    state_nxt = sasd_pkg::BK_CONVERT;
      sasd_pkg::BK_CONVERT: state_nxt = sasd_pkg::BK_SPLIT;
      sasd_pkg::BK_SPLIT:   state_nxt = sasd_pkg::BK_EMIT;
      sasd_pkg::BK_EMIT: begin
        if (out_load && pos_r == sasd_pkg::POS_UNIT) begin
          state_nxt = sasd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sasd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sasd_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring divide, one quotient bit per cycle
  assign rem_ge = rem_r >= den_r;

  // Gain multiply operands: Celsius removes the offset first
  assign quot_ext = {1'b0, quot_r};
  assign mul_a = fahr_r ? signed'(quot_ext) : signed'(quot_ext - {1'b0, sasd_pkg::C_OFFSET});
  assign mul_b = fahr_r ? signed'({1'b0, sasd_pkg::F_GAIN})
                        : signed'({2'b00, sasd_pkg::C_GAIN});
  assign prod_c = mul_a * mul_b;

  // Fahrenheit removes its offset after the multiply
  assign p_c = prod_r - (fahr_r ? sasd_pkg::F_OFFSET_Q32 : PW'(0));

  // Split the reading into decimal digits
  always_comb begin
    if (reading_r >= 8'd200) begin
      hund_c   = 4'd2;
      rem100_c = reading_r - 8'd200;
    end else if (reading_r >= 8'd100) begin
      hund_c   = 4'd1;
      rem100_c = reading_r - 8'd100;
    end else begin
      hund_c   = 4'd0;
      rem100_c = reading_r;
    end
    tens_prod = 16'(rem100_c) * DIV10_MUL;
    tens_c    = tens_prod[DIV10_SHIFT +: 4];
    ones_c    = rem100_c - (8'({tens_c, 3'b000}) + 8'({tens_c, 1'b0}));
    if (reading_r >= 8'd100) begin
      pos_start = sasd_pkg::POS_HUND;
    end else if (reading_r >= 8'd10) begin
      pos_start = sasd_pkg::POS_TENS;
    end else if (reading_r != 8'd0) begin
      pos_start = sasd_pkg::POS_ONES;
    end else begin
      pos_start = sasd_pkg::POS_UNIT;
    end
  end

  // Pick the pattern for the current position
  always_comb begin
    case (pos_r)
      sasd_pkg::POS_HUND: seg_c = sasd_pkg::digit_seg(hund_r);
      sasd_pkg::POS_TENS: seg_c = sasd_pkg::digit_seg(tens_r);
      sasd_pkg::POS_ONES: seg_c = sasd_pkg::digit_seg(ones_r);
      default:            seg_c = fahr_r ? sasd_pkg::SEG_F : sasd_pkg::SEG_C;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      sasd_pkg::BK_IDLE: begin
        fahr_r <= q_job[0];
        rem_r  <= WORK_W'(scaled);
        den_r  <= WORK_W'(divisor) << (QW - 1);
        quot_r <= '0;
        step_r <= '0;
      end
      sasd_pkg::BK_DIVIDE: begin
        if (rem_ge) begin
          rem_r <= rem_r - den_r;
        end
        den_r  <= den_r >> 1;
        quot_r <= {quot_r[QW-2:0], rem_ge};
        step_r <= step_r + STEP_W'(1);
      end
      sasd_pkg::BK_GAIN: begin
        prod_r <= prod_c;
      end
      sasd_pkg::BK_CONVERT: begin
        if (!p_c[PW-1] && p_c != PW'(0)) begin
          reading_r <= p_c[sasd_pkg::READ_LSB +: sasd_pkg::READ_W];
        end else begin
          reading_r <= '0;
        end
      end
      sasd_pkg::BK_SPLIT: begin
        hund_r <= hund_c;
        tens_r <= tens_c;
        ones_r <= ones_c[3:0];
        pos_r  <= pos_start;
      end
      sasd_pkg::BK_EMIT: begin
        if (out_load && pos_r != sasd_pkg::POS_UNIT) begin
          pos_r <= sasd_pkg::digit_pos_t'(pos_r + 2'd1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == sasd_pkg::BK_EMIT && out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sasd_pkg::BK_EMIT && out_load) begin
      out_tdata_r <= seg_c;
      out_tlast_r <= pos_r == sasd_pkg::POS_UNIT;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
`default_nettype wire

FILE: rtl/core/sensor_average_to_segment_digits_core.sv
// Sensor averaging core with seven-segment digit output.
// Input stream: in_tdata carries one converter sample, in_tuser the unit
//   choice (1 Fahrenheit, 0 Celsius), taken from the sample closing a window.
// Output stream: out_tdata is one segment pattern; the digits of the reading
//   come most significant first, then the unit letter with out_tlast high.
// Config: APB register 0 (byte address 0) sets the window length, read back.
// Throughput: one sample per cycle while the window queue has room. Each
//   reading occupies the back end for the bit-serial divide, then the gain,
//   convert and split steps, and one emit step per output item.
// The front end queues up to two finished windows; when both are waiting,
//   in_tready drops until the back end takes one.
// Stall: out_tready low holds the output register; the front end keeps
//   accepting samples until the queue fills.
// Reset: clears the open window and the queue, sets the window length
//   to 1000 samples; no clearing pass is needed.
`default_nettype none
`include "sensor_average_to_segment_digits_core_assert.svh"
module sensor_average_to_segment_digits_core #(
  parameter int unsigned ADC_BITS    = 12,
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [sasd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // adc_sample in the low ADC_BITS bits, zero padded to whole bytes
  input  wire logic [((ADC_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // unit_is_fahrenheit
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // segments (bit0 a .. bit6 g, bit7 point)
  output logic [7:0]                                out_tdata,
  output logic                                      out_tlast
);

  localparam int unsigned IN_DATA_W = ((ADC_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W     = ADC_BITS + $clog2(MAX_SAMPLES);
  localparam int unsigned JOB_W     = SUM_W + CNT_W + 1;

  logic [sasd_pkg::SAMPLE_COUNT_W-1:0] sample_count_r;
  logic                                cfg_wr;
  logic                                cfg_hit;
  logic                                q_push;
  logic                                q_pop;
  logic [JOB_W-1:0]                    q_job_in;
  logic [JOB_W-1:0]                    q_job_out;
  sasd_pkg::queue_status_t             q_status;
  logic                                out_is_unit;

  // Configuration register access
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[sasd_pkg::CFG_ADDR_W-1:2] == sasd_pkg::CFG_IDX_SAMPLE_COUNT;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? 32'(sample_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= sasd_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_wr && cfg_hit) begin
      sample_count_r <= cfg_pwdata[sasd_pkg::SAMPLE_COUNT_W-1:0];
    end
  end

  sasd_front #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .IN_DATA_W   (IN_DATA_W),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_count (sample_count_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_job        (q_job_in)
  );

  sasd_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_job_in),
    .pop       (q_pop),
    .pop_data  (q_job_out),
    .status    (q_status)
  );

  sasd_back #(
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W),
    .JOB_W    (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_job      (q_job_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Flag an output pattern that is a unit letter
  assign out_is_unit = out_tdata == sasd_pkg::SEG_C || out_tdata == sasd_pkg::SEG_F;

  // Front never pushes into a full queue
  `SASD_ASSERT_IMPLY(a_push_has_room, clk, rst_n, q_push, !q_status.full)
  // Back only pops a waiting window
  `SASD_ASSERT_IMPLY(a_pop_has_item, clk, rst_n, q_pop, !q_status.empty)
  // Back stays busy after taking a window, so pops never come back to back
  `SASD_ASSERT_NEXT(a_pop_spaced, clk, rst_n, q_pop, !q_pop)
  // Only the unit letter closes a reading
  `SASD_ASSERT_IMPLY(a_last_is_unit, clk, rst_n, out_tvalid, out_tlast == out_is_unit)

endmodule
`default_nettype wire

FILE: tb/segment_reading_checker.sv
module segment_reading_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sasd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  input  logic                             cfg_pready,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // adc_sample [11:0], zero padding [15:12]
  input  logic [15:0]                      in_tdata,
  // unit_is_fahrenheit
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // segments [7:0]
  input  logic [7:0]                       out_tdata,
  input  logic                             out_tlast,
  output int                               mismatch_count,
  output int                               glyphs_pending,
  output int                               readings_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Window length after reset and its legal span
  localparam logic [12:0] RESET_WINDOW = 13'd1000;
  localparam logic [12:0] WINDOW_MAX   = 13'd4096;

  // Fixed-point conversion constants (Q16 scale, Q32 products)
  localparam logic [63:0]        VOLT_SCALE_Q16 = 64'd216269;
  localparam logic [63:0]        ADC_FULL_SCALE = 64'd4095;
  localparam logic signed [63:0] C_OFFSET_Q16   = 64'sd26214;
  localparam logic signed [63:0] C_GAIN_Q16     = 64'sd3360821;
  localparam logic signed [63:0] F_GAIN_Q16     = 64'sd6049477;
  localparam logic signed [63:0] F_OFFSET_Q16   = 64'sd4516943;
  localparam logic signed [63:0] Q16_ONE        = 64'sd65536;

  // Seven-segment glyphs: digit d sits at bits [8d+7:8d]
  localparam logic [79:0] DIGIT_GLYPHS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };
  localparam logic [7:0] CELSIUS_GLYPH    = 8'h39;
  localparam logic [7:0] FAHRENHEIT_GLYPH = 8'h71;

  typedef struct packed {
    logic [7:0] glyph;
    logic       is_unit;
  } glyph_item_t;

  glyph_item_t expected_glyphs[$];
  logic [12:0] window_target;
  logic [23:0] window_sum;
  logic [12:0] window_taken;

  // Clamp the register to the window lengths the block supports
  function automatic logic [12:0] window_span(input logic [12:0] target);
    if (target == 13'd0) return 13'd1;
    if (target > WINDOW_MAX) return WINDOW_MAX;
    return target;
  endfunction

  // Mean volts, then degrees truncated toward zero, clipped at zero
  function automatic logic [7:0] reading_degrees(input logic [23:0] total,
                                                 input logic [12:0] count,
                                                 input logic fahrenheit);
    logic [63:0]        volts_q16;
    logic signed [63:0] degrees_q32;
    volts_q16 = ({40'd0, total} * VOLT_SCALE_Q16) / ({51'd0, count} * ADC_FULL_SCALE);
    if (fahrenheit)
      degrees_q32 = $signed(volts_q16) * F_GAIN_Q16 - F_OFFSET_Q16 * Q16_ONE;
    else
      degrees_q32 = ($signed(volts_q16) - C_OFFSET_Q16) * C_GAIN_Q16;
    if (degrees_q32 <= 0) return 8'd0;
    return degrees_q32[39:32];
  endfunction

  function automatic void queue_glyph(input logic [7:0] glyph, input logic is_unit);
    glyph_item_t entry;
    entry.glyph   = glyph;
    entry.is_unit = is_unit;
    expected_glyphs.push_back(entry);
  endfunction

  function automatic logic [7:0] digit_glyph(input logic [7:0] digit);
    return DIGIT_GLYPHS[digit * 8 +: 8];
  endfunction

  initial begin
    mismatch_count   = 0;
    glyphs_pending   = 0;
    readings_checked = 0;
    window_target    = RESET_WINDOW;
    window_sum       = '0;
    window_taken     = '0;
  end

  always @(posedge clk) begin
    glyph_item_t want;
    logic [7:0]  degrees;
    if (!rst_n) begin
      // Drop everything on reset
      window_target = RESET_WINDOW;
      window_sum    = '0;
      window_taken  = '0;
      expected_glyphs.delete();
    end else begin
      // Compare each delivered item with the oldest expected glyph
      if (out_tvalid && out_tready) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected segment item %h last %b, nothing pending",
                   $time, out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = expected_glyphs.pop_front();
          if (out_tdata !== want.glyph || out_tlast !== want.is_unit) begin
            $display("%0t: segment item mismatch: expected %h last %b, got %h last %b",
                     $time, want.glyph, want.is_unit, out_tdata, out_tlast);
            mismatch_count++;
          end
          if (want.is_unit) readings_checked++;
        end
      end

      // Accumulate samples; on the closing one, predict the displayed reading
      if (in_tvalid && in_tready) begin
        window_sum   = window_sum + in_tdata[11:0];
        window_taken = window_taken + 13'd1;
        if (window_taken >= window_span(window_target)) begin
          degrees = reading_degrees(window_sum, window_taken, in_tuser);
          if (degrees >= 8'd100) queue_glyph(digit_glyph(degrees / 8'd100), 1'b0);
          if (degrees >= 8'd10) queue_glyph(digit_glyph((degrees / 8'd10) % 8'd10), 1'b0);
          if (degrees >= 8'd1) queue_glyph(digit_glyph(degrees % 8'd10), 1'b0);
          queue_glyph(in_tuser ? FAHRENHEIT_GLYPH : CELSIUS_GLYPH, 1'b1);
          window_sum   = '0;
          window_taken = '0;
        end
      end

      // Track register writes; other addresses are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[sasd_pkg::CFG_ADDR_W-1:2] == sasd_pkg::CFG_IDX_SAMPLE_COUNT)
        window_target = cfg_pwdata[12:0];
    end
    glyphs_pending = expected_glyphs.size();
  end

endmodule

FILE: tb/sensor_average_to_segment_digits_core_tb.sv
module sensor_average_to_segment_digits_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [0:0] SPARE_REG_IDX = 1'b1;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 20;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [sasd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]                     cfg_pwdata;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [15:0]                     in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [7:0]                      out_tdata;
  logic                            out_tlast;

  int   mismatch_count;
  int   glyphs_pending;
  int   readings_checked;
  int   samples_sent;
  int   quiet_cycles;
  logic busy_mode;
  logic hold_off_request;

  sensor_average_to_segment_digits_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  segment_reading_checker reading_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tlast        (out_tlast),
    .mismatch_count   (mismatch_count),
    .glyphs_pending   (glyphs_pending),
    .readings_checked (readings_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly random samples, with the rails drawn often
  function automatic logic [11:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offer one sample after a random gap (none in busy mode) and hold it until accepted
  task automatic send_sample(input logic [11:0] sample, input logic fahrenheit);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, 16);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {4'h0, sample};
      in_tuser  <= fahrenheit;
    end
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(draw_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Stop offering, wait for every pending glyph, then let the back end go quiet
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (glyphs_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {idx, 2'b00};
      cfg_pwdata  <= value;
    end
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
  endtask

  // Set the window length once idle; upper data bits carry noise
  task automatic program_window(input logic [12:0] length);
    logic [31:0] noise;
    noise = $urandom;
    settle();
    write_reg(sasd_pkg::CFG_IDX_SAMPLE_COUNT, {noise[31:13], length});
  endtask

  // Result side: random hold-off per item (none in busy mode), one long stall on request
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_request) begin
        gap = LONG_HOLD;
        hold_off_request = 1'b0;
      end else if (busy_mode) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 16);
      end
      repeat (gap) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [12:0] phase_lengths [8];
    int          p;
    rst_n            = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    busy_mode        = 1'b0;
    hold_off_request = 1'b0;
    samples_sent     = 0;
    quiet_cycles     = 0;
    phase_lengths    = '{13'd1, 13'd2, 13'd3, 13'd5, 13'd8, 13'd1, 13'd4, 13'd16};

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Window length left at its reset value: the window stays open
    send_random(24);

    // Lowering the length closes the open window on the next item
    program_window(13'd1);
    send_random(1);

    // Single-sample windows: rails, near-zero readings, digits three and six
    send_sample(12'd0, 1'b0);
    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd496, 1'b0);
    send_sample(12'd520, 1'b0);
    send_sample(12'd581, 1'b0);
    send_sample(12'd654, 1'b0);
    send_sample(12'd1380, 1'b0);
    send_sample(12'd2033, 1'b0);
    send_sample(12'd900, 1'b1);
    send_sample(12'd2048, 1'b1);
    send_sample(12'hAAA, 1'b0);
    send_sample(12'h555, 1'b1);

    // Zero in the register acts as one
    program_window(13'd0);
    send_random(3);

    // A write to an unused address leaves the window length alone
    program_window(13'd2);
    write_reg(SPARE_REG_IDX, $urandom);
    send_random(6);

    // Shorten the window from six to two while four samples are in it
    program_window(13'd6);
    send_random(4);
    program_window(13'd2);
    send_random(5);

    // Oversize length acts as the maximum; keep one long window open across a rewrite
    program_window(13'd8191);
    busy_mode = 1'b1;
    repeat (40) send_sample(12'hFFF, 1'b1);
    program_window(13'd4096);
    send_random(40);
    busy_mode = 1'b0;

    // Random phases over a spread of window lengths; the first closes the long window
    for (p = 0; p < 8; p++) begin
      program_window(phase_lengths[p]);
      busy_mode = (p == 2 || p == 5);
      send_random(PHASE_ITEMS);
    end
    busy_mode = 1'b0;

    // Stall the result side long enough to back up the input
    program_window(13'd1);
    hold_off_request = 1'b1;
    send_random(16);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d samples and checked %0d readings over register values 0 to 8191,",
             samples_sent, readings_checked);
    $display("both units, mid-window changes, an unused address and a long output stall.");
    if (glyphs_pending != 0)
      $display("%0t: %0d expected segment items never arrived", $time, glyphs_pending);
    if (mismatch_count == 0 && glyphs_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
